[sv/tcse_pkg.sv]
// Shared types and constants of the text console screen engine.
`timescale 1ns / 1ps

package tcse_pkg;

   // Fixed widths of the word fields on the ports.
   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int IDX_W   = 11;
   localparam int POS_W   = 11;
   localparam int OCOL_W  = 7;
   localparam int OROW_W  = 5;
   localparam int CELL_W  = 16;

   // Operation codes carried by an input word.
   localparam logic [OP_W-1:0] OP_PUT       = 2'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;
   localparam logic [OP_W-1:0] OP_READ      = 2'd3;

   // Character code that starts a new line.
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   // Attribute used for blank cells straight after reset.
   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;

   // Work classes handed from the front end to the back end.
   typedef enum logic [2:0] {
      KIND_PRINT,
      KIND_NEWLINE,
      KIND_BACKSPACE,
      KIND_CLEAR,
      KIND_READ
   } kind_type;

   // One classified command as it sits in the queue.
   typedef struct packed {
      kind_type            kind;
      logic [CHAR_W-1:0]   character;
      logic [COLOR_W-1:0]  color;
      logic [IDX_W-1:0]    cell_index;
      logic                in_range;
   } cmd_type;

endpackage

[sv/text_console_screen_engine.sv]
// Top level of the text console screen engine.
`timescale 1ns / 1ps

// Text console engine with a COLUMNS x ROWS screen store of 16-bit cells
// (attribute in the high byte, character in the low byte) and a write cursor.
// Input words are classified and queued (two entries), then carried out by a
// sequencer that owns the screen store, so words can still be queued while a
// result waits to be taken. A word first updates the cursor, then a printed
// character or backspace writes its cell, then the addressed cell is read for
// the result; a line feed on the bottom row scrolls by rotating the row ring
// and blanking one row. Clear sweeps all COLUMNS*ROWS cells, 2000 by default.
// The same sweep runs after reset, and no word is accepted until it is done;
// the colour register can still be written meanwhile.
module text_console_screen_engine import tcse_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [COLOR_W-1:0]  csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [CHAR_W-1:0]   req_character,
   input  logic [COLOR_W-1:0]  req_color,
   input  logic [IDX_W-1:0]    req_cell_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_cursor_position,
   output logic [OCOL_W-1:0]   rsp_cursor_column,
   output logic [OROW_W-1:0]   rsp_cursor_row,
   output logic [CELL_W-1:0]   rsp_cell_value
);

   logic    init_busy;
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // Classification of incoming words.
   tcse_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_character  (req_character),
      .req_color      (req_color),
      .req_cell_index (req_cell_index),
      .init_busy      (init_busy),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_cmd       (push_cmd)
   );

   // Decoupling queue.
   tcse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Execution and result register.
   tcse_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_cmd             (pop_cmd),
      .init_busy           (init_busy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cell_value      (rsp_cell_value)
   );

endmodule

[sv/tcse_front.sv]
// Front end: accepts input words and classifies them into commands.
`timescale 1ns / 1ps

module tcse_front import tcse_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [CHAR_W-1:0]   req_character,
   input  logic [COLOR_W-1:0]  req_color,
   input  logic [IDX_W-1:0]    req_cell_index,
   input  logic                init_busy,
   output logic                push_valid,
   input  logic                push_ready,
   output cmd_type             push_cmd
);

   localparam int CELLS = COLUMNS * ROWS;

   kind_type kind;

   // Decode the operation; a newline is its own class of work.
   always_comb begin
      unique case (req_operation)
         OP_PUT: begin
            kind = (req_character == NEWLINE_CODE) ? KIND_NEWLINE : KIND_PRINT;
         end
         OP_BACKSPACE: begin
            kind = KIND_BACKSPACE;
         end
         OP_CLEAR: begin
            kind = KIND_CLEAR;
         end
         OP_READ: begin
            kind = KIND_READ;
         end
         default: begin
            kind = KIND_READ;
         end
      endcase
   end

   // Build the command word, including the range check of the read address.
   always_comb begin
      push_cmd.kind       = kind;
      push_cmd.character  = req_character;
      push_cmd.color      = req_color;
      push_cmd.cell_index = req_cell_index;
      push_cmd.in_range   = (32'(req_cell_index) < 32'(CELLS));
   end

   // No word is taken while the screen store is being cleared after reset.
   assign push_valid = req_valid && !init_busy;
   assign req_ready  = push_ready && !init_busy;

endmodule

[sv/tcse_queue.sv]
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module tcse_queue import tcse_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  cmd_type  push_cmd,
   output logic     pop_valid,
   input  logic     pop_ready,
   output cmd_type  pop_cmd
);

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/tcse_back.sv]
// Back end: cursor state, screen store sequencer and result register.
`timescale 1ns / 1ps

module tcse_back import tcse_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [COLOR_W-1:0]  csr_write_data,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  cmd_type             pop_cmd,
   output logic                init_busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_cursor_position,
   output logic [OCOL_W-1:0]   rsp_cursor_column,
   output logic [OROW_W-1:0]   rsp_cursor_row,
   output logic [CELL_W-1:0]   rsp_cell_value
);

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int COL_W     = $clog2(COLUMNS + 1);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int LPOS_W    = $clog2(CELLS + 1);
   localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SCROLL,
      S_PUT,
      S_ERASE,
      S_READ,
      S_DATA
   } state_type;

   state_type            state_ff,      state_in;
   cmd_type              cmd_ff,        cmd_in;
   logic [COL_W-1:0]     col_ff,        col_in;
   logic [ROW_W-1:0]     row_ff,        row_in;
   logic [ADDR_W-1:0]    base_ff,       base_in;
   logic [ADDR_W-1:0]    offset_ff,     offset_in;
   logic [ADDR_W-1:0]    sweep_ff,      sweep_in;
   logic [LPOS_W-1:0]    shown_ff,      shown_in;
   logic                 clear_reply_ff, clear_reply_in;
   logic [COLOR_W-1:0]   color_ff,      color_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   logic [POS_W-1:0]     rsp_pos_ff,    rsp_pos_in;
   logic [OCOL_W-1:0]    rsp_col_ff,    rsp_col_in;
   logic [OROW_W-1:0]    rsp_row_ff,    rsp_row_in;
   logic [CELL_W-1:0]    rsp_cell_ff,   rsp_cell_in;

   logic [CELL_W-1:0]    screen_mem [CELLS];
   logic [CELL_W-1:0]    rd_data_ff;

   logic [ADDR_W-1:0]    lin_addr;
   logic [ADDR_W:0]      phys_sum;
   logic [ADDR_W-1:0]    phys_addr;
   logic [ADDR_W:0]      offset_sum;
   logic [ADDR_W-1:0]    offset_next;
   logic [LPOS_W-1:0]    cursor_lin;
   logic [CELL_W-1:0]    blank_cell;
   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [CELL_W-1:0]    mem_wr_data;
   logic                 mem_rd_en;
   logic                 line_advance;
   logic                 slot_free;

   // The reset pass uses the reset colour; every other blanking uses the register.
   assign blank_cell = {(init_busy ? RESET_COLOR : color_ff), 8'h00};

   // Linear address of the access made in this state.
   always_comb begin
      case (state_ff)
         S_SCROLL: lin_addr = ADDR_W'(LAST_BASE) + sweep_ff;
         S_READ:   lin_addr = cmd_ff.in_range ? ADDR_W'(cmd_ff.cell_index) : '0;
         default:  lin_addr = ADDR_W'(col_ff) + base_ff;
      endcase
   end

   // Rows are stored as a ring: the top screen row starts at offset_ff.
   assign phys_sum  = {1'b0, lin_addr} + {1'b0, offset_ff};
   assign phys_addr = (phys_sum >= (ADDR_W + 1)'(CELLS)) ?
                      ADDR_W'(phys_sum - (ADDR_W + 1)'(CELLS)) : ADDR_W'(phys_sum);

   // Ring start after one scroll.
   assign offset_sum  = {1'b0, offset_ff} + (ADDR_W + 1)'(COLUMNS);
   assign offset_next = (offset_sum >= (ADDR_W + 1)'(CELLS)) ?
                        ADDR_W'(offset_sum - (ADDR_W + 1)'(CELLS)) : ADDR_W'(offset_sum);

   assign cursor_lin = LPOS_W'(col_ff) + LPOS_W'(base_ff);
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // A line feed is needed for a newline or for a print past the last column.
   assign line_advance = (cmd_ff.kind == KIND_NEWLINE) ||
                         ((cmd_ff.kind == KIND_PRINT) && (col_ff >= COL_W'(COLUMNS)));

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      base_in        = base_ff;
      offset_in      = offset_ff;
      sweep_in       = sweep_ff;
      shown_in       = shown_ff;
      clear_reply_in = clear_reply_ff;
      color_in       = csr_write_enable ? csr_write_data : color_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pos_in     = rsp_pos_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_cell_in    = rsp_cell_ff;
      pop_ready      = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = phys_addr;
      mem_wr_data    = blank_cell;
      mem_rd_en      = 1'b0;

      unique case (state_ff)
         // Blank every cell, one a cycle.
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               sweep_in = '0;
               state_in = clear_reply_ff ? S_READ : S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in   = pop_cmd;
               state_in = S_EXEC;
            end
         end

         // Cursor movement for the command in hand.
         S_EXEC: begin
            case (cmd_ff.kind)
               KIND_PRINT, KIND_NEWLINE: begin
                  if (line_advance) begin
                     col_in = '0;
                     if (row_ff == ROW_W'(ROWS - 1)) begin
                        offset_in = offset_next;
                        sweep_in  = '0;
                        state_in  = S_SCROLL;
                     end else begin
                        row_in   = row_ff + 1'b1;
                        base_in  = base_ff + ADDR_W'(COLUMNS);
                        state_in = (cmd_ff.kind == KIND_PRINT) ? S_PUT : S_READ;
                     end
                  end else begin
                     state_in = S_PUT;
                  end
               end
               KIND_BACKSPACE: begin
                  if (col_ff == '0) begin
                     if (row_ff != '0) begin
                        row_in  = row_ff - 1'b1;
                        base_in = base_ff - ADDR_W'(COLUMNS);
                     end
                  end else begin
                     col_in = col_ff - 1'b1;
                  end
                  state_in = S_ERASE;
               end
               KIND_CLEAR: begin
                  col_in         = '0;
                  row_in         = '0;
                  base_in        = '0;
                  offset_in      = '0;
                  sweep_in       = '0;
                  clear_reply_in = 1'b1;
                  state_in       = S_CLEAR;
               end
               default: begin
                  state_in = S_READ;
               end
            endcase
         end

         // Blank the new bottom row, which is the old top row of the ring.
         S_SCROLL: begin
            mem_wr_en = 1'b1;
            if (sweep_ff == ADDR_W'(COLUMNS - 1)) begin
               sweep_in = '0;
               state_in = (cmd_ff.kind == KIND_PRINT) ? S_PUT : S_READ;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {cmd_ff.color, cmd_ff.character};
            shown_in    = cursor_lin + 1'b1;
            col_in      = col_ff + 1'b1;
            state_in    = S_READ;
         end

         S_ERASE: begin
            mem_wr_en = 1'b1;
            shown_in  = cursor_lin;
            state_in  = S_READ;
         end

         S_READ: begin
            mem_rd_en = 1'b1;
            state_in  = S_DATA;
         end

         // Load the result register once it is free.
         S_DATA: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pos_in     = POS_W'(shown_ff);
               rsp_col_in     = OCOL_W'(col_ff);
               rsp_row_in     = OROW_W'(row_ff);
               rsp_cell_in    = cmd_ff.in_range ? rd_data_ff : '0;
               clear_reply_in = 1'b0;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         col_ff         <= '0;
         row_ff         <= '0;
         base_ff        <= '0;
         offset_ff      <= '0;
         sweep_ff       <= '0;
         shown_ff       <= '0;
         clear_reply_ff <= 1'b0;
         color_ff       <= RESET_COLOR;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         base_ff        <= base_in;
         offset_ff      <= offset_in;
         sweep_ff       <= sweep_in;
         shown_ff       <= shown_in;
         clear_reply_ff <= clear_reply_in;
         color_ff       <= color_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // Screen store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         screen_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= screen_mem[phys_addr];
      end
   end

   assign init_busy           = (state_ff == S_CLEAR) && !clear_reply_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cell_value      = rsp_cell_ff;

endmodule

[sv/tcse_checker.sv]
// Port-level checks for the text console screen engine, bound to the top level.
`timescale 1ns / 1ps

module tcse_checker import tcse_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [POS_W-1:0]    rsp_cursor_position,
   input logic [OCOL_W-1:0]   rsp_cursor_column,
   input logic [OROW_W-1:0]   rsp_cursor_row,
   input logic [CELL_W-1:0]   rsp_cell_value
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_position) &&
         $stable(rsp_cursor_column) && $stable(rsp_cursor_row) && $stable(rsp_cell_value))
      else $error("result word changed while stalled");

   // Reset starts the clearing sweep: nothing is taken or offered.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block active straight after reset");

   // The reported write cursor stays on the screen; its column may also sit at COLUMNS.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_row) < 32'(ROWS)) &&
         (32'(rsp_cursor_column) <= 32'(COLUMNS)))
      else $error("reported cursor off the screen");

endmodule

bind text_console_screen_engine tcse_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcse_checker (.*);

[dv/screen_reply_checker.sv]
// Checker that predicts and compares the result words of the text console screen engine.
`timescale 1ns / 1ps

module screen_reply_checker import tcse_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [COLOR_W-1:0] csr_write_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [CHAR_W-1:0]  req_character,
   input  logic [COLOR_W-1:0] req_color,
   input  logic [IDX_W-1:0]   req_cell_index,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [POS_W-1:0]   rsp_cursor_position,
   input  logic [OCOL_W-1:0]  rsp_cursor_column,
   input  logic [OROW_W-1:0]  rsp_cursor_row,
   input  logic [CELL_W-1:0]  rsp_cell_value,
   output int                 mismatches,
   output int                 pending
);

   localparam int CELLS = COLUMNS * ROWS;

   // One result word as the block should present it.
   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [OCOL_W-1:0] column;
      logic [OROW_W-1:0] row;
      logic [CELL_W-1:0] contents;
   } reply_type;

   // Shadow copy of the console: screen store, write cursor, shown cursor and colour.
   logic [CELL_W-1:0]  screen [CELLS];
   logic [OCOL_W-1:0]  cur_column;
   logic [OROW_W-1:0]  cur_row;
   logic [POS_W-1:0]   shown_position;
   logic [COLOR_W-1:0] blank_color;
   reply_type          due_replies [$];

   function automatic logic [CELL_W-1:0] blank_cell();
      return {blank_color, {CHAR_W{1'b0}}};
   endfunction

   task automatic report_mismatch(input string what);
      // Printing stops after a while so a badly broken block cannot flood the log.
      if (mismatches < 200) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      mismatches++;
   endtask

   task automatic blank_screen();
      for (int i = 0; i < CELLS; i++) begin
         screen[i] = blank_cell();
      end
      cur_column = '0;
      cur_row    = '0;
   endtask

   // Once the cursor runs off the bottom, everything moves up a row and the last row is blanked.
   task automatic scroll_when_full();
      if (cur_row < ROWS) begin
         return;
      end
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
         screen[i] = screen[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
         screen[i] = blank_cell();
      end
      cur_column = '0;
      cur_row    = OROW_W'(ROWS - 1);
   endtask

   task automatic line_feed();
      cur_column = '0;
      cur_row++;
      scroll_when_full();
   endtask

   // Carry out one input word on the shadow console and work out its result word.
   task automatic apply_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [COLOR_W-1:0] color, input logic [IDX_W-1:0] idx,
                             output reply_type want);
      int cell_at;
      case (op)
         OP_PUT: begin
            if (ch == NEWLINE_CODE) begin
               line_feed();
            end else begin
               // A full row wraps before the character is placed.
               if (cur_column >= COLUMNS) begin
                  line_feed();
               end
               scroll_when_full();
               cell_at = int'(cur_column) + int'(cur_row) * COLUMNS;
               if (cell_at < CELLS) begin
                  screen[cell_at] = {color, ch};
               end
               shown_position = POS_W'(cell_at + 1);
               cur_column++;
            end
         end
         OP_BACKSPACE: begin
            // At the start of a row the cursor climbs one row, but never above the top.
            if (cur_column == 0) begin
               if (cur_row > 0) begin
                  cur_row--;
               end
            end else begin
               cur_column--;
            end
            cell_at = int'(cur_column) + int'(cur_row) * COLUMNS;
            if (cell_at < CELLS) begin
               screen[cell_at] = blank_cell();
            end
            shown_position = POS_W'(cell_at);
         end
         OP_CLEAR: begin
            blank_screen();
         end
         OP_READ: begin
            // Reading changes nothing; the cell is reported below as for every word.
         end
         default: begin
         end
      endcase
      want.position = shown_position;
      want.column   = cur_column;
      want.row      = cur_row;
      want.contents = (idx < CELLS) ? screen[idx] : '0;
   endtask

   task automatic check_reply(input reply_type got);
      reply_type want;
      if (due_replies.size() == 0) begin
         report_mismatch("result word arrived with nothing outstanding");
         return;
      end
      want = due_replies.pop_front();
      if (got.position !== want.position) begin
         report_mismatch($sformatf("cursor position %0d, expected %0d",
                                   got.position, want.position));
      end
      if (got.column !== want.column) begin
         report_mismatch($sformatf("cursor column %0d, expected %0d", got.column, want.column));
      end
      if (got.row !== want.row) begin
         report_mismatch($sformatf("cursor row %0d, expected %0d", got.row, want.row));
      end
      if (got.contents !== want.contents) begin
         report_mismatch($sformatf("cell value %h, expected %h", got.contents, want.contents));
      end
   endtask

   // Results are retired before new words are predicted, as they belong to older words.
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         blank_color = RESET_COLOR;
         blank_screen();
         shown_position = '0;
         due_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_cursor_position, rsp_cursor_column, rsp_cursor_row, rsp_cell_value};
            check_reply(got);
         end
         if (csr_write_enable) begin
            blank_color = csr_write_data;
         end
         if (req_valid && req_ready) begin
            apply_word(req_operation, req_character, req_color, req_cell_index, want);
            due_replies.push_back(want);
         end
      end
      pending <= due_replies.size();
   end

endmodule

[dv/text_console_screen_engine_tb.sv]
// Testbench top of the text console screen engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module text_console_screen_engine_tb;
   import tcse_pkg::*;

   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int CELLS     = COLUMNS * ROWS;
   localparam int LONG_HOLD = 300;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [COLOR_W-1:0] csr_write_data   = '0;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [OP_W-1:0]    req_operation    = OP_READ;
   logic [CHAR_W-1:0]  req_character    = '0;
   logic [COLOR_W-1:0] req_color        = '0;
   logic [IDX_W-1:0]   req_cell_index   = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [POS_W-1:0]   rsp_cursor_position;
   logic [OCOL_W-1:0]  rsp_cursor_column;
   logic [OROW_W-1:0]  rsp_cursor_row;
   logic [CELL_W-1:0]  rsp_cell_value;

   int mismatches;
   int pending;
   int words_sent;
   int replies_taken;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_screen_engine #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_character      (req_character),
      .req_color          (req_color),
      .req_cell_index     (req_cell_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cursor_position(rsp_cursor_position),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cell_value     (rsp_cell_value)
   );

   screen_reply_checker #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_character      (req_character),
      .req_color          (req_color),
      .req_cell_index     (req_cell_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cursor_position(rsp_cursor_position),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cell_value     (rsp_cell_value),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   // Offer one input word after a random gap; every fourth stretch of words runs back to back.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [COLOR_W-1:0] color, input logic [IDX_W-1:0] idx);
      int unsigned gap;
      gap = ((words_sent % 64) >= 48) ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation  <= op;
      req_character  <= ch;
      req_color      <= color;
      req_cell_index <= idx;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Stop offering and wait until every result word has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_blank_color(input logic [COLOR_W-1:0] color);
      csr_write_enable <= 1'b1;
      csr_write_data   <= color;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Cells near the top and the bottom row see the most change; the rest spans the whole index.
   function automatic logic [IDX_W-1:0] pick_cell();
      case ($urandom_range(0, 3))
         0:       return IDX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
         1:       return IDX_W'($urandom_range(0, 2 * COLUMNS - 1));
         default: return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      endcase
   endfunction

   // A line of text, now and then long enough to wrap, mostly closed by a newline.
   task automatic type_line();
      int unsigned length;
      if ($urandom_range(0, 7) == 0) begin
         length = $urandom_range(COLUMNS - 5, COLUMNS + 20);
      end else begin
         length = $urandom_range(0, 20);
      end
      for (int i = 0; i < length; i++) begin
         send_word(OP_PUT, CHAR_W'($urandom_range(0, 255)), COLOR_W'($urandom), pick_cell());
      end
      if ($urandom_range(0, 4) != 0) begin
         send_word(OP_PUT, NEWLINE_CODE, COLOR_W'($urandom), pick_cell());
      end
   endtask

   task automatic random_phase(input int target);
      int first;
      int unsigned pick;
      first = words_sent;
      while (words_sent - first < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            type_line();
         end else if (pick < 70) begin
            // Runs of newlines reach the bottom row quickly and make the screen scroll.
            repeat ($urandom_range(1, 12)) begin
               send_word(OP_PUT, NEWLINE_CODE, COLOR_W'($urandom), pick_cell());
            end
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 6)) begin
               send_word(OP_BACKSPACE, CHAR_W'($urandom), COLOR_W'($urandom), pick_cell());
            end
         end else if (pick < 97) begin
            send_word(OP_READ, CHAR_W'($urandom), COLOR_W'($urandom), pick_cell());
         end else begin
            send_word(OP_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), pick_cell());
         end
      end
   endtask

   // Result side: random stalls, stretches without stalls, and one long hold-off
   // during which the block fills up and stops taking input words.
   initial begin : result_taker
      int unsigned hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (replies_taken == 100) begin
            hold = LONG_HOLD;
         end else if ((replies_taken % 80) >= 60) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 9);
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         replies_taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [COLOR_W-1:0] phase_color [4];
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // The block sweeps its store after reset; the colour is changed only once that is done.
      while (!req_ready) @(negedge clock);
      set_blank_color(8'hFF);

      // Directed words: reads at the ends and beyond the store, backspace at the top left,
      // extreme characters and colours, newline, backspace over a row start and clear.
      send_word(OP_READ, 8'h00, 8'h00, IDX_W'(0));
      send_word(OP_READ, 8'hFF, 8'hFF, IDX_W'(CELLS - 1));
      send_word(OP_READ, 8'h00, 8'h00, IDX_W'(CELLS));
      send_word(OP_READ, 8'h00, 8'h00, '1);
      send_word(OP_BACKSPACE, 8'h00, 8'h00, IDX_W'(0));
      send_word(OP_PUT, 8'h41, 8'h00, IDX_W'(0));
      send_word(OP_PUT, 8'hFF, 8'hFF, IDX_W'(1));
      send_word(OP_PUT, 8'h00, 8'h5A, IDX_W'(2));
      send_word(OP_BACKSPACE, 8'h00, 8'h00, IDX_W'(2));
      send_word(OP_PUT, NEWLINE_CODE, 8'hAA, IDX_W'(1));
      send_word(OP_BACKSPACE, 8'h00, 8'h00, IDX_W'(0));
      send_word(OP_PUT, NEWLINE_CODE, 8'h00, IDX_W'(0));
      send_word(OP_PUT, NEWLINE_CODE, 8'h00, IDX_W'(0));
      send_word(OP_PUT, 8'h7E, 8'h81, IDX_W'(2 * COLUMNS));
      send_word(OP_PUT, 8'h0B, 8'h0F, IDX_W'(2 * COLUMNS + 1));
      send_word(OP_PUT, 8'h09, 8'hF0, IDX_W'(2 * COLUMNS + 2));
      send_word(OP_READ, 8'h00, 8'h00, IDX_W'(2 * COLUMNS + 1));
      send_word(OP_CLEAR, 8'h55, 8'h55, IDX_W'(2 * COLUMNS));
      send_word(OP_READ, 8'hAA, 8'hAA, IDX_W'(2 * COLUMNS));
      send_word(OP_PUT, 8'h80, 8'h7F, IDX_W'(1024));
      send_word(OP_BACKSPACE, 8'h00, 8'h00, IDX_W'(0));
      send_word(OP_BACKSPACE, 8'h00, 8'h00, IDX_W'(0));

      // Random phases, each under a new blank colour: two fixed, two random.
      phase_color[0] = 8'h00;
      phase_color[1] = COLOR_W'($urandom);
      phase_color[2] = 8'h80;
      phase_color[3] = COLOR_W'($urandom);
      for (int p = 0; p < 4; p++) begin
         drain();
         set_blank_color(phase_color[p]);
         random_phase(135);
      end

      drain();
      repeat (100) @(negedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Guard against a hung block.
   initial begin : watchdog
      #50_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
